### hdl/mbrtu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbrtu_pkg
// shared constants and crc helper for the modbus rtu slave frame handler
// ----------------------------------------------------------------------------
package mbrtu_pkg;

	localparam int unsigned BUFFER_BYTES = 128;
	localparam int unsigned FRAME_LEN    = 8;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [7:0] SLAVE_ADDR_RESET = 8'hFE;
	localparam logic [7:0] FC_READ          = 8'h03;
	localparam logic [7:0] FC_WRITE         = 8'h06;
	localparam logic [7:0] READ_BYTE_COUNT  = 8'h02;

	localparam logic [15:0] REG_STATUS = 16'h0000;
	localparam logic [15:0] REG_ORDERS = 16'h0001;

	localparam logic [2:0] READ_BODY_LEN  = 3'd5;
	localparam logic [2:0] WRITE_BODY_LEN = 3'd6;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### hdl/modbus_rtu_slave_frame_handler_unit.sv
// an accepted byte is registered in the input stage and decoded from there; a byte
// that completes a valid request loads the reply buffer, which then offers the first beat
// throughput: one rx byte per cycle; a reply (7 or 8 beats) streams one beat per cycle
// while m_tready is high; only a byte completing a new reply waits on an older reply
// reset: asynchronous, active low; idle phase, empty buffer, orders cleared,
// slave address 0xfe
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_handler_unit
// receives rtu frames bytewise, answers read of status (fc 3) and write of
// orders (fc 6) with a crc16 protected reply stream
// ----------------------------------------------------------------------------
module modbus_rtu_slave_frame_handler_unit #(
	parameter int unsigned BUFFER_BYTES = mbrtu_pkg::BUFFER_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,   // bus_addr
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,     // rx_byte[7:0], status_value[23:8]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,     // tx_byte[7:0], orders_value[23:8], orders_updated[24]
	output logic             m_tlast
);

	localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FCODE = 2'd1,
		PH_FRAME = 2'd2
	} phase_t;

	logic [7:0]       slave_q;
	logic             s1_valid_q;
	logic [7:0]       rx_s1;
	logic [15:0]      status_s1;
	phase_t           phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      fcrc_q;
	logic [7:0]       fb_q [1:6];
	logic [15:0]      orders_q;

	logic             rb_busy_q;
	logic [7:0]       rb_q [0:5];
	logic [2:0]       len_q;
	logic [2:0]       idx_q;
	logic [15:0]      crc_q;
	logic [15:0]      rb_orders_q;
	logic             rb_upd_q;

	logic             full;
	logic [CNT_W-1:0] cnt_inc;
	logic             frame_end;
	logic [15:0]      req_reg;
	logic [15:0]      wr_val;
	logic             crc_ok;
	logic             is_read;
	logic             is_write;
	logic             reply_go;
	logic             out_fire;
	logic             out_done;
	logic             proc;
	logic [7:0]       tx_byte;

	always_comb begin
		full      = cnt_q >= CNT_W'(BUFFER_BYTES);
		cnt_inc   = cnt_q + CNT_W'(1);
		frame_end = !full && (phase_q == PH_FRAME) && (cnt_q == CNT_W'(mbrtu_pkg::FRAME_LEN - 1));
		req_reg   = {fb_q[2], fb_q[3]};
		wr_val    = {fb_q[4], fb_q[5]};
		crc_ok    = {rx_s1, fb_q[6]} == fcrc_q;
		is_read   = (fb_q[1] == mbrtu_pkg::FC_READ) && (req_reg == mbrtu_pkg::REG_STATUS);
		is_write  = (fb_q[1] == mbrtu_pkg::FC_WRITE) && (req_reg == mbrtu_pkg::REG_ORDERS);
		reply_go  = frame_end && crc_ok && (is_read || is_write);
	end

	assign out_fire = m_tvalid && m_tready;
	assign out_done = out_fire && m_tlast;
	assign proc     = s1_valid_q && (!reply_go || !rb_busy_q || out_done);
	assign s_tready = !s1_valid_q || proc;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= mbrtu_pkg::SLAVE_ADDR_RESET;
		end else if (cfg_we) begin
			slave_q <= cfg_wdata;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid_q <= 1'b1;
		end else if (proc) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_s1     <= s_tdata[7:0];
			status_s1 <= s_tdata[23:8];
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			orders_q <= '0;
		end else if (proc) begin
			if (full) begin
				cnt_q <= '0;
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						if (rx_s1 == slave_q) begin
							cnt_q   <= CNT_W'(1);
							phase_q <= PH_FCODE;
						end else begin
							cnt_q <= cnt_inc;
						end
					end
					PH_FCODE: begin
						if (rx_s1 == mbrtu_pkg::FC_READ || rx_s1 == mbrtu_pkg::FC_WRITE) begin
							phase_q <= PH_FRAME;
							cnt_q   <= cnt_inc;
						end else begin
							phase_q <= PH_IDLE;
							cnt_q   <= '0;
						end
					end
					PH_FRAME: begin
						if (frame_end) begin
							phase_q <= PH_IDLE;
							cnt_q   <= '0;
							if (reply_go && is_write) begin
								orders_q <= wr_val;
							end
						end else begin
							cnt_q <= cnt_inc;
						end
					end
					default: begin
						phase_q <= PH_IDLE;
						cnt_q   <= '0;
					end
				endcase
			end
		end
	end

	// running crc over frame bytes 0..5 and frame byte store
	always_ff @(posedge clk) begin
		if (proc && !full) begin
			if (phase_q == PH_IDLE && rx_s1 == slave_q) begin
				fcrc_q <= mbrtu_pkg::crc_byte(mbrtu_pkg::CRC_INIT, rx_s1);
			end else if (phase_q == PH_FCODE || (phase_q == PH_FRAME && cnt_q <= CNT_W'(5))) begin
				fcrc_q <= mbrtu_pkg::crc_byte(fcrc_q, rx_s1);
			end
			if (cnt_q >= CNT_W'(1) && cnt_q <= CNT_W'(6)) begin
				fb_q[cnt_q[2:0]] <= rx_s1;
			end
		end
	end

	// reply buffer and serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rb_busy_q <= 1'b0;
			idx_q     <= '0;
		end else if (proc && reply_go) begin
			rb_busy_q <= 1'b1;
			idx_q     <= '0;
		end else if (out_done) begin
			rb_busy_q <= 1'b0;
		end else if (out_fire) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && reply_go) begin
			crc_q       <= mbrtu_pkg::CRC_INIT;
			rb_q[0]     <= slave_q;
			rb_upd_q    <= is_write;
			rb_orders_q <= is_write ? wr_val : orders_q;
			if (is_write) begin
				len_q   <= mbrtu_pkg::WRITE_BODY_LEN;
				rb_q[1] <= mbrtu_pkg::FC_WRITE;
				rb_q[2] <= fb_q[2];
				rb_q[3] <= fb_q[3];
				rb_q[4] <= fb_q[4];
				rb_q[5] <= fb_q[5];
			end else begin
				len_q   <= mbrtu_pkg::READ_BODY_LEN;
				rb_q[1] <= mbrtu_pkg::FC_READ;
				rb_q[2] <= mbrtu_pkg::READ_BYTE_COUNT;
				rb_q[3] <= status_s1[15:8];
				rb_q[4] <= status_s1[7:0];
			end
		end else if (out_fire && idx_q < len_q) begin
			crc_q <= mbrtu_pkg::crc_byte(crc_q, tx_byte);
		end
	end

	always_comb begin
		if (idx_q < len_q) begin
			tx_byte = rb_q[idx_q];
		end else if (idx_q == len_q) begin
			tx_byte = crc_q[7:0];
		end else begin
			tx_byte = crc_q[15:8];
		end
	end

	assign m_tvalid = rb_busy_q;
	assign m_tlast  = idx_q == (len_q + 3'd1);
	assign m_tdata  = {7'd0, rb_upd_q, rb_orders_q, tx_byte};

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		rb_busy_q |-> (idx_q <= len_q + 3'd1))
		else $error("reply index past end of reply");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BUFFER_BYTES))
		else $error("byte count beyond buffer size");

	a_frame_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FRAME) |-> (cnt_q >= CNT_W'(2) && cnt_q <= CNT_W'(7)))
		else $error("frame phase with bad byte count");

	a_reply_load: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && reply_go) |=> (rb_busy_q && idx_q == 3'd0))
		else $error("reply not loaded");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && reply_go && rb_busy_q && !out_done) |-> !s_tready)
		else $error("input accepted while reply buffer occupied");
`endif

endmodule
`default_nettype wire

### tb/sv/tb_modbus_rtu_slave_frame_handler_unit.sv
// ----------------------------------------------------------------------------
// tb_modbus_rtu_slave_frame_handler_unit
// feeds received bus bytes into the frame handler and checks every reply beat
// against a behavioral model of the slave kept inside the bench: directed
// frames first, then random frames and noise under several slave addresses,
// with random gaps and stalls on both streams
// ----------------------------------------------------------------------------
module tb_modbus_rtu_slave_frame_handler_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [1:0] {LINK_IDLE, LINK_FCODE, LINK_FRAME} link_t;
	typedef logic [7:0][7:0] frame8_t;

	typedef struct packed {
		logic [7:0]  tx;
		logic        last;
		logic [15:0] orders;
		logic        upd;
	} reply_beat_t;

	typedef struct {
		logic [7:0]  rx;
		logic [15:0] status;
		bit          quiet;
	} rx_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = 24'h000000;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;

	// slave model state
	logic [7:0]  node_addr = mbrtu_pkg::SLAVE_ADDR_RESET;
	link_t       link = LINK_IDLE;
	int          rx_count = 0;
	frame8_t     rx_buf = '0;
	logic [15:0] orders = 16'h0000;

	reply_beat_t reply_due[$];
	rx_row_t     rx_plan[$];

	bit no_idle = 1'b0;
	int errors = 0;
	int sent = 0;
	int beats = 0;
	int replies = 0;
	int cycles = 0;

	modbus_rtu_slave_frame_handler_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [15:0] crc16(input frame8_t bytes, input int len);
		logic [15:0] acc;
		acc = mbrtu_pkg::CRC_INIT;
		for (int i = 0; i < len; i++) begin
			acc = acc ^ {8'h00, bytes[i]};
			repeat (8) acc = {1'b0, acc[15:1]} ^ (acc[0] ? mbrtu_pkg::CRC_POLY : 16'h0000);
		end
		return acc;
	endfunction

	function automatic logic [15:0] pick16();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 16'h0000;
		if (r == 1) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic void plan_row(input logic [7:0] rx, input logic [15:0] status,
			input bit quiet);
		rx_row_t row;
		row.rx = rx;
		row.status = status;
		row.quiet = quiet;
		rx_plan.push_back(row);
	endfunction

	// rtu request: addr, fc, reg hi/lo, word hi/lo, crc lo/hi
	function automatic void plan_frame(input logic [7:0] addr, input logic [7:0] fc,
			input logic [15:0] regno, input logic [15:0] word, input bit spoil,
			input bit quiet, input logic [15:0] last_status, input int nbytes);
		frame8_t f;
		logic [15:0] crc;
		f = '0;
		f[0] = addr;
		f[1] = fc;
		f[2] = regno[15:8];
		f[3] = regno[7:0];
		f[4] = word[15:8];
		f[5] = word[7:0];
		crc = crc16(f, 6);
		if (spoil) crc = crc ^ (16'h0001 << $urandom_range(15));
		f[6] = crc[7:0];
		f[7] = crc[15:8];
		for (int k = 0; k < nbytes; k++) begin
			plan_row(f[k], (k == 7) ? last_status : pick16(), quiet);
		end
	endfunction

	task automatic slave_take_byte(input logic [7:0] rx, input logic [15:0] status,
			input bit quiet);
		frame8_t msg;
		logic [15:0] crc;
		reply_beat_t beat;
		int body;
		bit wrote;
		body = 0;
		wrote = 1'b0;
		msg = '0;
		if (rx_count >= mbrtu_pkg::BUFFER_BYTES) begin
			rx_count = 0;
			return;
		end
		if (rx_count < mbrtu_pkg::FRAME_LEN) rx_buf[rx_count] = rx;
		rx_count++;
		case (link)
			LINK_IDLE: begin
				if (rx == node_addr) begin
					rx_buf[0] = rx;
					rx_count = 1;
					link = LINK_FCODE;
				end
			end
			LINK_FCODE: begin
				if (rx == mbrtu_pkg::FC_READ || rx == mbrtu_pkg::FC_WRITE) begin
					link = LINK_FRAME;
				end else begin
					link = LINK_IDLE;
					rx_count = 0;
				end
			end
			default: begin
				if (rx_count == mbrtu_pkg::FRAME_LEN) begin
					link = LINK_IDLE;
					rx_count = 0;
					if ({rx_buf[7], rx_buf[6]} == crc16(rx_buf, 6)) begin
						if (rx_buf[1] == mbrtu_pkg::FC_READ &&
								{rx_buf[2], rx_buf[3]} == mbrtu_pkg::REG_STATUS) begin
							msg[0] = node_addr;
							msg[1] = mbrtu_pkg::FC_READ;
							msg[2] = mbrtu_pkg::READ_BYTE_COUNT;
							msg[3] = status[15:8];
							msg[4] = status[7:0];
							body = int'(mbrtu_pkg::READ_BODY_LEN);
						end else if (rx_buf[1] == mbrtu_pkg::FC_WRITE &&
								{rx_buf[2], rx_buf[3]} == mbrtu_pkg::REG_ORDERS) begin
							orders = {rx_buf[4], rx_buf[5]};
							msg = rx_buf;
							msg[0] = node_addr;
							body = int'(mbrtu_pkg::WRITE_BODY_LEN);
							wrote = 1'b1;
						end
					end
				end
			end
		endcase
		if (body != 0) begin
			crc = crc16(msg, body);
			msg[body] = crc[7:0];
			msg[body + 1] = crc[15:8];
			replies++;
			if (!quiet) begin
				for (int k = 0; k < body + 2; k++) begin
					beat.tx = msg[k];
					beat.last = (k == body + 1);
					beat.orders = orders;
					beat.upd = wrote;
					reply_due.push_back(beat);
				end
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] rx, input logic [15:0] status,
			input bit quiet);
		while (!no_idle && $urandom_range(99) < 34) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {status, rx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
		slave_take_byte(rx, status, quiet);
	endtask

	// send the plan, then close any open frame so the slave ends idle
	task automatic run_plan();
		rx_row_t row;
		while (rx_plan.size() != 0) begin
			row = rx_plan.pop_front();
			send_byte(row.rx, row.status, row.quiet);
		end
		while (link != LINK_IDLE) send_byte(8'h00, pick16(), 1'b0);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (reply_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	function automatic void check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(99) >= 34);
	end

	always @(posedge clk) begin : beat_check
		reply_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (reply_due.size() == 0) begin
				errors++;
				$display("%0t: reply beat with nothing pending, expected none, actual %h last %b",
					$time, m_tdata, m_tlast);
			end else begin
				want = reply_due.pop_front();
				beats++;
				check_field("tx_byte", {8'h00, want.tx}, {8'h00, m_tdata[7:0]});
				check_field("last_byte", {15'h0, want.last}, {15'h0, m_tlast});
				check_field("orders_value", want.orders, m_tdata[23:8]);
				check_field("orders_updated", {15'h0, want.upd}, {15'h0, m_tdata[24]});
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_modbus_rtu_slave_frame_handler_unit: done, errors");
		$finish;
	end

	initial begin : stimulus
		int k;
		int base;
		int addr_settings;
		logic [7:0] b;
		logic [7:0] fc;
		logic [7:0] new_addr;
		logic [15:0] regno;
		logic [15:0] target;
		addr_settings = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset address
		plan_row(mbrtu_pkg::SLAVE_ADDR_RESET, 16'h0000, 1'b1);
		plan_row(8'h00, 16'h0000, 1'b1);
		plan_row(8'hFF, 16'hFFFF, 1'b1);
		plan_frame(mbrtu_pkg::SLAVE_ADDR_RESET, mbrtu_pkg::FC_READ, mbrtu_pkg::REG_STATUS,
			16'h0001, 1'b0, 1'b0, 16'hFFFF, 8);
		plan_frame(mbrtu_pkg::SLAVE_ADDR_RESET, mbrtu_pkg::FC_WRITE, mbrtu_pkg::REG_ORDERS,
			16'hFFFF, 1'b0, 1'b0, pick16(), 8);
		plan_frame(mbrtu_pkg::SLAVE_ADDR_RESET, mbrtu_pkg::FC_WRITE, mbrtu_pkg::REG_ORDERS,
			16'h1234, 1'b1, 1'b1, 16'h0000, 8);
		run_plan();

		for (int ph = 1; ph <= 4; ph++) begin
			wait_drained();
			new_addr = (ph == 1) ? 8'h00 : (ph == 2) ? 8'hFF : 8'($urandom_range(1, 254));
			cfg_we <= 1'b1;
			cfg_wdata <= new_addr;
			@(posedge clk);
			cfg_we <= 1'b0;
			node_addr = new_addr;
			addr_settings++;
			no_idle = (ph == 2);

			base = rx_plan.size();
			while (rx_plan.size() - base < 14) begin
				k = $urandom_range(99);
				fc = $urandom_range(1) ? mbrtu_pkg::FC_READ : mbrtu_pkg::FC_WRITE;
				target = (fc == mbrtu_pkg::FC_READ) ? mbrtu_pkg::REG_STATUS :
					mbrtu_pkg::REG_ORDERS;
				if (k < 30) begin
					plan_frame(node_addr, mbrtu_pkg::FC_READ, mbrtu_pkg::REG_STATUS,
						16'($urandom), 1'b0, 1'b0, pick16(), 8);
				end else if (k < 60) begin
					plan_frame(node_addr, mbrtu_pkg::FC_WRITE, mbrtu_pkg::REG_ORDERS,
						pick16(), 1'b0, 1'b0, pick16(), 8);
				end else if (k < 68) begin
					regno = 16'($urandom);
					if (regno == target) regno = regno + 16'h0001;
					plan_frame(node_addr, fc, regno, pick16(), 1'b0, 1'b0, pick16(), 8);
				end else if (k < 76) begin
					plan_frame(node_addr, fc, target, pick16(), 1'b1, 1'b0, pick16(), 8);
				end else if (k < 82) begin
					b = 8'($urandom);
					if (b == mbrtu_pkg::FC_READ || b == mbrtu_pkg::FC_WRITE) b = ~b;
					plan_frame(node_addr, b, target, pick16(), 1'b0, 1'b0, pick16(), 8);
				end else if (k < 88) begin
					plan_frame(node_addr ^ 8'($urandom_range(1, 255)), fc, target, pick16(),
						1'b0, 1'b0, pick16(), 8);
				end else if (k < 94) begin
					repeat ($urandom_range(1, 4)) plan_row(8'($urandom), pick16(), 1'b0);
				end else begin
					plan_frame(node_addr, fc, target, pick16(), 1'b0, 1'b0, pick16(),
						$urandom_range(1, 7));
				end
			end
			run_plan();
		end
		wait_drained();
		no_idle = 1'b0;

		$display("run covered %0d rx beats under %0d slave addresses", sent, addr_settings);
		$display("%0d reply frames predicted, %0d reply beats compared", replies, beats);
		if (errors == 0) begin
			$display("tb_modbus_rtu_slave_frame_handler_unit: done, clean");
		end else begin
			$display("tb_modbus_rtu_slave_frame_handler_unit: done, errors");
		end
		$finish;
	end

endmodule

### modbus_rtu_slave_frame_handler_unit.f
hdl/mbrtu_pkg.sv
hdl/modbus_rtu_slave_frame_handler_unit.sv
tb/sv/tb_modbus_rtu_slave_frame_handler_unit.sv
